FILE: rtl/core/f2pcm_pkg.sv
// Format codes and shared constants for the float to PCM sample encoder.
package f2pcm_pkg;

  localparam logic [3:0] FMT_U8  = 4'd0;
  localparam logic [3:0] FMT_S8  = 4'd1;
  localparam logic [3:0] FMT_U16 = 4'd2;
  localparam logic [3:0] FMT_S16 = 4'd3;
  localparam logic [3:0] FMT_U24 = 4'd4;
  localparam logic [3:0] FMT_S24 = 4'd5;
  localparam logic [3:0] FMT_U32 = 4'd6;
  localparam logic [3:0] FMT_S32 = 4'd7;
  localparam logic [3:0] FMT_F32 = 4'd8;
  localparam logic [3:0] FMT_F64 = 4'd9;

  localparam logic REG_FORMAT = 1'b0;
  localparam logic REG_ORDER  = 1'b1;

  localparam logic [3:0] CNT_1 = 4'd1;
  localparam logic [3:0] CNT_2 = 4'd2;
  localparam logic [3:0] CNT_3 = 4'd3;
  localparam logic [3:0] CNT_4 = 4'd4;
  localparam logic [3:0] CNT_8 = 4'd8;

  // Integer width selector (format code bits 2:1)
  localparam logic [1:0] W8  = 2'd0;
  localparam logic [1:0] W16 = 2'd1;
  localparam logic [1:0] W24 = 2'd2;
  localparam logic [1:0] W32 = 2'd3;

endpackage

FILE: rtl/core/float_to_pcm_sample_encoder_core.sv
// A sample passes through an input register and then a result register.
// Throughput: one sample per cycle; out_stall on a full result stage holds the input.
// The conversion (24x31 multiply, round, shift) sits between the two registers.
// Reset: rst_n synchronous, active low; clears valids, format to s16, order little-endian.
module float_to_pcm_sample_encoder_core
  import f2pcm_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_sample_bits,
  input  logic        in_last_in_block,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_pcm_bytes,
  output logic [3:0]  out_byte_count,
  output logic        out_last_out
);

  logic [3:0]  fmt_r;
  logic        order_r;
  logic        s1_valid_r;
  logic [31:0] s1_bits_r;
  logic        s1_last_r;
  logic        out_valid_r;
  logic [63:0] out_bytes_r;
  logic [3:0]  out_cnt_r;
  logic        out_last_r;
  logic        s2_adv;
  logic        s1_load;
  logic        cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite;
  assign cfg_prdata = (cfg_paddr[2] == REG_ORDER) ? {31'd0, order_r} : {28'd0, fmt_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r   <= FMT_S16;
      order_r <= 1'b0;
    end else if (cfg_wr) begin
      if (cfg_paddr[2] == REG_FORMAT) fmt_r <= cfg_pwdata[3:0];
      else order_r <= cfg_pwdata[0];
    end
  end

  assign s2_adv   = !out_valid_r || !out_stall;
  assign in_stall = s1_valid_r && !s2_adv;
  assign s1_load  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_bits_r <= in_sample_bits;
      s1_last_r <= in_last_in_block;
    end
  end

  // Conversion datapath
  logic [3:0]  fmt;
  logic [1:0]  wsel;
  logic        sgn;
  logic [7:0]  ex;
  logic [22:0] man;
  logic [30:0] mag;
  logic [30:0] scale;
  logic [23:0] sig;
  logic [54:0] prod;
  logic        lead;
  logic [4:0]  sh;
  logic [54:0] q;
  logic        dbl;
  logic        rb, st, lsb, up;
  logic [54:0] lowmask;
  logic [55:0] kval;
  logic [8:0]  tsh;
  logic [55:0] ishift;
  logic [31:0] imag;
  logic [31:0] ival;
  logic [31:0] uval;
  logic [63:0] val;
  logic [3:0]  cnt;
  logic [63:0] bytes;
  logic [4:0]  k;
  logic [10:0] dexp;
  logic [22:0] dman;
  logic [63:0] dval;

  always_comb begin
    fmt  = (fmt_r > FMT_F64) ? FMT_S16 : fmt_r;
    wsel = fmt[2:1];
    sgn  = s1_bits_r[31];
    ex   = s1_bits_r[30:23];
    man  = s1_bits_r[22:0];
    mag  = s1_bits_r[30:0];
    case (wsel)
      W8:      scale = 31'h7f;
      W16:     scale = 31'h7fff;
      W24:     scale = 31'h7fffff;
      default: scale = 31'h7fffffff;
    endcase
    sig  = {(ex != 8'd0), man};
    prod = {31'd0, sig} * {24'd0, scale};
    // Leading one of the exact product sits at one of two places
    case (wsel)
      W8:      begin lead = prod[30]; sh = lead ? 5'd24 : 5'd25; end
      W16:     begin lead = prod[38]; sh = lead ? 5'd16 : 5'd17; end
      W24:     begin lead = prod[46]; sh = lead ? 5'd8  : 5'd9;  end
      default: begin lead = prod[54]; sh = lead ? 5'd0  : 5'd1;  end
    endcase
    q   = prod << sh;
    dbl = (wsel == W32);
    // Round to nearest even at single or double precision
    if (dbl) begin
      rb = q[1]; st = q[0]; lsb = q[2]; lowmask = 55'h3;
    end else begin
      rb = q[30]; st = |q[29:0]; lsb = q[31]; lowmask = 55'h7fffffff;
    end
    up   = rb && (st || lsb);
    kval = {1'b0, q & ~lowmask} + (up ? (dbl ? 56'd4 : 56'h80000000) : 56'd0);
    tsh  = 9'd150 + {4'd0, sh} - {1'b0, ex};
    ishift = (tsh >= 9'd56) ? 56'd0 : (kval >> tsh);
    if (mag > 31'h7f800000)      imag = 32'd0;
    else if (mag >= 31'h3f800000) imag = {1'b0, scale};
    else if (ex == 8'd0)          imag = 32'd0;
    else                          imag = ishift[31:0];
    ival = sgn ? (32'd0 - imag) : imag;
    uval = ival;
    if (!fmt[0]) begin
      case (wsel)
        W8:      uval = ival + 32'h80;
        W16:     uval = ival + 32'h8000;
        W24:     uval = ival + 32'h800000;
        default: uval = ival + 32'h80000000;
      endcase
    end
    case (wsel)
      W8:      uval = uval & 32'hff;
      W16:     uval = uval & 32'hffff;
      W24:     uval = uval & 32'hffffff;
      default: uval = uval;
    endcase

    // Exact widening to double
    k    = 5'd0;
    dexp = 11'd0;
    dman = 23'd0;
    for (int i = 0; i < 23; i++) begin
      if (man[i]) k = 5'(i);
    end
    if (ex == 8'hff) begin
      dval = {sgn, 11'h7ff, man, 29'd0};
      if (man != 23'd0) dval[51] = 1'b1;
    end else if (ex == 8'd0) begin
      dexp = 11'd874 + {6'd0, k};
      dman = man << (5'd23 - k);
      dval = (man == 23'd0) ? {sgn, 63'd0} : {sgn, dexp, dman, 29'd0};
    end else begin
      dexp = {3'd0, ex} + 11'd896;
      dval = {sgn, dexp, man, 29'd0};
    end

    case (fmt)
      FMT_F32: begin val = {32'd0, s1_bits_r}; cnt = CNT_4; end
      FMT_F64: begin val = dval; cnt = CNT_8; end
      default: begin
        val = {32'd0, uval};
        case (wsel)
          W8:      cnt = CNT_1;
          W16:     cnt = CNT_2;
          W24:     cnt = CNT_3;
          default: cnt = CNT_4;
        endcase
      end
    endcase

    bytes = val;
    if (order_r) begin
      case (cnt)
        CNT_2: bytes = {48'd0, val[7:0], val[15:8]};
        CNT_3: bytes = {40'd0, val[7:0], val[15:8], val[23:16]};
        CNT_4: bytes = {32'd0, val[7:0], val[15:8], val[23:16], val[31:24]};
        CNT_8: begin
          for (int i = 0; i < 8; i++) bytes[8*i +: 8] = val[8*(7-i) +: 8];
        end
        default: bytes = val;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s2_adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_adv && s1_valid_r) begin
      out_bytes_r <= bytes;
      out_cnt_r   <= cnt;
      out_last_r  <= s1_last_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_pcm_bytes  = out_bytes_r;
  assign out_byte_count = out_cnt_r;
  assign out_last_out   = out_last_r;

endmodule

FILE: rtl/core/f2pcm_checker.sv
// Port-level checks for the float to PCM sample encoder, bound to float_to_pcm_sample_encoder_core.
module f2pcm_checker
  import f2pcm_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [63:0] out_pcm_bytes,
  input logic [3:0]  out_byte_count,
  input logic        cfg_pready
);

  a_cnt_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_byte_count == CNT_1 || out_byte_count == CNT_2 ||
                   out_byte_count == CNT_3 || out_byte_count == CNT_4 ||
                   out_byte_count == CNT_8))
    else $error("illegal byte count");

  a_unused_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_byte_count != CNT_8) |-> (out_pcm_bytes[63:32] == 32'd0))
    else $error("unused bytes not zero");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_pcm_bytes)))
    else $error("stalled transfer changed");

  a_pready: assert property (@(posedge clk) cfg_pready)
    else $error("pready low");

endmodule

bind float_to_pcm_sample_encoder_core f2pcm_checker u_f2pcm_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_pcm_bytes (out_pcm_bytes),
  .out_byte_count(out_byte_count),
  .cfg_pready    (cfg_pready)
);
